// ----- rtl/core/button_hold_autorepeat_macros.svh -----
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BUTTON_HOLD_AUTOREPEAT_MACROS_SVH
`define BUTTON_HOLD_AUTOREPEAT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("button_hold_autorepeat: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("button_hold_autorepeat: next-cycle check failed");

`endif

// ----- rtl/core/bha_pkg.sv -----
`timescale 1ns / 1ps

package bha_pkg;

    // Button array geometry.
    localparam int BUTTON_COUNT = 64;
    localparam int MASK_W       = 64;
    localparam int BTN_IDX_W    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int BTN_CNT_W    = $clog2(BUTTON_COUNT + 1);

    // Per-button counters.
    localparam int HOLD_W  = 9;
    localparam int PHASE_W = 8;
    localparam logic [HOLD_W-1:0] HOLD_MAX = 9'd256;

    // Configuration registers.
    localparam int CFG_DATA_W = 8;
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_DATA_W-1:0] DEFAULT_DELAY = 8'd15;
    localparam logic [CFG_DATA_W-1:0] DEFAULT_RATE  = 8'd4;
    localparam logic [CFG_DATA_W-1:0] REPEAT_OFF    = 8'd255;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_REPEAT_DELAY = 2'd0,
        CFG_REPEAT_RATE  = 2'd1
    } cfg_reg_e;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } bha_state_e;

    // One entry of the state memory.
    typedef struct packed {
        logic [HOLD_W-1:0]  hold;
        logic [PHASE_W-1:0] phase;
    } bha_entry_t;

    // Result of updating one button for one frame.
    typedef struct packed {
        bha_entry_t entry;
        logic       held;
        logic       fire;
    } bha_upd_t;

endpackage

// ----- rtl/core/bha_state_ram.sv -----
`timescale 1ns / 1ps

module bha_state_ram (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [bha_pkg::BTN_IDX_W-1:0] rd_addr,
    output bha_pkg::bha_entry_t       rd_data,
    input  logic                      wr_en,
    input  logic [bha_pkg::BTN_IDX_W-1:0] wr_addr,
    input  bha_pkg::bha_entry_t       wr_data
);
    import bha_pkg::*;

    bha_entry_t                mem [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0]   valid_reg;
    bha_entry_t                rd_word_reg;
    logic                      rd_valid_reg;

    // Storage array with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // Written flags: an entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// ----- rtl/core/bha_update.sv -----
`timescale 1ns / 1ps

module bha_update (
    input  logic                           press,
    input  bha_pkg::bha_entry_t            cur,
    input  logic [bha_pkg::CFG_DATA_W-1:0] repeat_delay,
    input  logic [bha_pkg::CFG_DATA_W-1:0] repeat_rate,
    output bha_pkg::bha_upd_t              upd
);
    import bha_pkg::*;

    logic [CFG_DATA_W-1:0] delay_eff;
    logic [CFG_DATA_W-1:0] rate_eff;
    logic                  repeat_on;
    logic [HOLD_W-1:0]     hold_inc;
    logic [PHASE_W:0]      phase_inc;

    // Zero in a register selects the default timing.
    assign delay_eff = (repeat_delay == '0) ? DEFAULT_DELAY : repeat_delay;
    assign rate_eff  = (repeat_rate == '0) ? DEFAULT_RATE : repeat_rate;
    assign repeat_on = (delay_eff != REPEAT_OFF);

    assign hold_inc  = (cur.hold < HOLD_MAX) ? cur.hold + 1'b1 : cur.hold;
    assign phase_inc = {1'b0, cur.phase} + 1'b1;

    // One button for one frame: count the hold and time the autorepeat.
    always_comb
    begin
        upd = '0;
        if (press)
        begin
            upd.held       = 1'b1;
            upd.entry.hold = hold_inc;
            upd.fire       = (hold_inc == HOLD_W'(1));
            if (repeat_on && (hold_inc > {1'b0, delay_eff}))
            begin
                if (cur.phase == '0)
                begin
                    upd.fire = 1'b1;
                end
                // The phase wraps once it reaches the rate.
                if (phase_inc >= {1'b0, rate_eff})
                begin
                    upd.entry.phase = '0;
                end
                else
                begin
                    upd.entry.phase = phase_inc[PHASE_W-1:0];
                end
            end
        end
    end

endmodule

// ----- rtl/core/button_hold_autorepeat.sv -----
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    press_mask
// out       output     out_valid / out_ready  held_mask, pressed_mask
// cfg       input      cfg_we                 cfg_addr, cfg_wdata
//
// An item is swept from acceptance to a loaded result one button at a time,
// set by the single read port of the state memory: one button is read,
// updated and written back per cycle. The next item can be taken once the
// load has returned the sequencer to idle; a new item waits for the sweep.
// Reset clears the sequencer, the output valid flag and the memory's written
// flags, so all hold counts and phases read as zero at once; no clearing pass.
// A result waiting in the output register does not block the next item; only
// loading the following result waits for the register to drain.
`timescale 1ns / 1ps

module button_hold_autorepeat (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bha_pkg::MASK_W-1:0]     press_mask,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bha_pkg::MASK_W-1:0]     held_mask,
    output logic [bha_pkg::MASK_W-1:0]     pressed_mask,
    input  logic                           cfg_we,
    input  logic [bha_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bha_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bha_pkg::*;

    bha_state_e             state_reg, state_next;
    logic [CFG_DATA_W-1:0]  delay_reg, delay_next;
    logic [CFG_DATA_W-1:0]  rate_reg, rate_next;
    logic [MASK_W-1:0]      mask_reg, mask_next;
    logic [MASK_W-1:0]      held_acc_reg, held_acc_next;
    logic [MASK_W-1:0]      pressed_acc_reg, pressed_acc_next;
    logic [BTN_CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic [BTN_IDX_W-1:0]   s1_addr_reg, s1_addr_next;
    logic                   out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]      held_out_reg, held_out_next;
    logic [MASK_W-1:0]      pressed_out_reg, pressed_out_next;

    logic                   accept;
    logic                   issue;
    logic                   last_done;
    logic                   load_out;
    bha_entry_t             rd_data;
    bha_upd_t               upd;

    // State memory: read at the issue counter, written back in the following cycle.
    // Read and write addresses always differ, so no forwarding is needed.
    bha_state_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[BTN_IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (upd.entry)
    );

    bha_update u_update (
        .press        (mask_reg[s1_addr_reg]),
        .cur          (rd_data),
        .repeat_delay (delay_reg),
        .repeat_rate  (rate_reg),
        .upd          (upd)
    );

    assign accept    = in_valid && in_ready;
    assign last_done = s1_valid_reg && (s1_addr_reg == BTN_IDX_W'(BUTTON_COUNT - 1));

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_RUN:
            begin
                issue = (rd_cnt_reg < BTN_CNT_W'(BUTTON_COUNT));
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Configuration writes.
    always_comb
    begin
        delay_next = delay_reg;
        rate_next  = rate_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_REPEAT_DELAY: delay_next = cfg_wdata;
                CFG_REPEAT_RATE:  rate_next  = cfg_wdata;
                default:          delay_next = delay_reg;
            endcase
        end
    end

    // Button sweep: issue counter, update stage and mask accumulation.
    always_comb
    begin
        mask_next        = mask_reg;
        held_acc_next    = held_acc_reg;
        pressed_acc_next = pressed_acc_reg;
        rd_cnt_next      = rd_cnt_reg;
        s1_valid_next    = issue;
        s1_addr_next     = rd_cnt_reg[BTN_IDX_W-1:0];
        if (accept)
        begin
            mask_next        = press_mask;
            held_acc_next    = '0;
            pressed_acc_next = '0;
            rd_cnt_next      = '0;
        end
        else
        begin
            if (issue)
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
            end
            if (s1_valid_reg)
            begin
                held_acc_next    = held_acc_reg | (MASK_W'(upd.held) << s1_addr_reg);
                pressed_acc_next = pressed_acc_reg | (MASK_W'(upd.fire) << s1_addr_reg);
            end
        end
    end

    // Output register.
    always_comb
    begin
        held_out_next    = held_out_reg;
        pressed_out_next = pressed_out_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        if (load_out)
        begin
            held_out_next    = held_acc_reg;
            pressed_out_next = pressed_acc_reg;
            out_valid_next   = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            delay_reg     <= '0;
            rate_reg      <= '0;
            rd_cnt_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            delay_reg     <= delay_next;
            rate_reg      <= rate_next;
            rd_cnt_reg    <= rd_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        mask_reg        <= mask_next;
        held_acc_reg    <= held_acc_next;
        pressed_acc_reg <= pressed_acc_next;
        s1_addr_reg     <= s1_addr_next;
        held_out_reg    <= held_out_next;
        pressed_out_reg <= pressed_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign held_mask    = held_out_reg;
    assign pressed_mask = pressed_out_reg;

endmodule

// ----- rtl/core/bha_checker.sv -----
`timescale 1ns / 1ps
`include "button_hold_autorepeat_macros.svh"

module bha_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [bha_pkg::MASK_W-1:0]     held_mask,
    input logic [bha_pkg::MASK_W-1:0]     pressed_mask
);
    import bha_pkg::*;

    // A button can only fire on a frame in which it is held.
    `BHA_ASSERT_NOW(a_pressed_within_held, out_valid, (pressed_mask & ~held_mask) == '0)

    // The sweep keeps the block busy, so it is not ready right after an item.
    `BHA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // No result can come out of the sweep the cycle after an item enters.
    `BHA_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && !out_valid, !out_valid)

    // A stalled result holds its value.
    `BHA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(held_mask) && $stable(pressed_mask))

endmodule

bind button_hold_autorepeat bha_checker u_bha_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .held_mask    (held_mask),
    .pressed_mask (pressed_mask)
);

// ----- dv/button_hold_autorepeat_tb.sv -----
`timescale 1ns / 1ps

module button_hold_autorepeat_tb;

    import bha_pkg::*;

    // Register indexes past the end of the register list; writes to them are dropped.
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_HI = 2'd3;

    localparam int LONG_STALL       = 400;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 80;
    localparam int PHASES           = 14;
    localparam int FRAMES_PER_PHASE = 27;
    localparam int PLANNED_PHASES   = 7;

    // Register settings for the first phases: quick repeat, a high rate lowered
    // in the middle of a hold, repeat off, the top delay, and the defaults.
    localparam logic [CFG_DATA_W-1:0] PLAN_DELAY [PLANNED_PHASES] =
        '{8'd1, 8'd2, 8'd2, 8'd255, 8'd254, 8'd0, 8'd1};
    localparam logic [CFG_DATA_W-1:0] PLAN_RATE [PLANNED_PHASES] =
        '{8'd1, 8'd200, 8'd3, 8'd7, 8'd255, 8'd0, 8'd2};

    // Buttons held through every random phase but the last, so their hold counts saturate.
    localparam logic [MASK_W-1:0] LONG_HOLD = {1'b1, {(MASK_W-2){1'b0}}, 1'b1};

    typedef struct packed {
        logic [MASK_W-1:0] held;
        logic [MASK_W-1:0] pressed;
    } frame_masks_t;

    // Tracks hold counts and repeat phases and keeps the masks still owed by the block.
    class autorepeat_scoreboard;
        logic [HOLD_W-1:0]     hold_count [BUTTON_COUNT];
        logic [PHASE_W-1:0]    repeat_phase [BUTTON_COUNT];
        logic [CFG_DATA_W-1:0] delay_reg;
        logic [CFG_DATA_W-1:0] rate_reg;
        frame_masks_t          owed_masks [$];
        int                    failures;

        function new();
            foreach (hold_count[i])
            begin
                hold_count[i]   = '0;
                repeat_phase[i] = '0;
            end
            delay_reg = '0;
            rate_reg  = '0;
            failures  = 0;
        endfunction

        function void write_reg(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data);
            if (addr == CFG_REPEAT_DELAY)
                delay_reg = data;
            else if (addr == CFG_REPEAT_RATE)
                rate_reg = data;
        endfunction

        // Advance every button by one frame and queue the masks it produces.
        function void note_frame(input logic [MASK_W-1:0] mask);
            frame_masks_t res;
            int delay_eff;
            int rate_eff;
            int h;
            int p;
            int nxt;
            bit fire;
            delay_eff = (delay_reg == 0) ? int'(DEFAULT_DELAY) : int'(delay_reg);
            rate_eff  = (rate_reg == 0) ? int'(DEFAULT_RATE) : int'(rate_reg);
            res = '0;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                if (mask[i])
                begin
                    h = hold_count[i];
                    if (h < int'(HOLD_MAX))
                        h++;
                    hold_count[i] = h[HOLD_W-1:0];
                    res.held[i] = 1'b1;
                    fire = (h == 1);
                    if (delay_eff != int'(REPEAT_OFF) && h > delay_eff)
                    begin
                        p = repeat_phase[i];
                        if (p == 0)
                            fire = 1'b1;
                        nxt = p + 1;
                        if (nxt >= rate_eff)
                            nxt = 0;
                        repeat_phase[i] = nxt[PHASE_W-1:0];
                    end
                    else
                    begin
                        repeat_phase[i] = '0;
                    end
                    res.pressed[i] = fire;
                end
                else
                begin
                    hold_count[i]   = '0;
                    repeat_phase[i] = '0;
                end
            end
            owed_masks.push_back(res);
        endfunction

        function void check_result(input logic [MASK_W-1:0] held,
                                   input logic [MASK_W-1:0] pressed);
            frame_masks_t want;
            if (owed_masks.size() == 0)
            begin
                $error("result item with no frame waiting: held_mask %h pressed_mask %h",
                       held, pressed);
                failures++;
            end
            else
            begin
                want = owed_masks.pop_front();
                if (held !== want.held)
                begin
                    $error("held_mask mismatch: expected %h, actual %h", want.held, held);
                    failures++;
                end
                if (pressed !== want.pressed)
                begin
                    $error("pressed_mask mismatch: expected %h, actual %h",
                           want.pressed, pressed);
                    failures++;
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [MASK_W-1:0]     press_mask = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [MASK_W-1:0]     held_mask;
    logic [MASK_W-1:0]     pressed_mask;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    autorepeat_scoreboard board;
    int burst_left = 0;
    bit long_stall_req = 1'b0;

    button_hold_autorepeat dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .press_mask   (press_mask),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .held_mask    (held_mask),
        .pressed_mask (pressed_mask),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Check every result item as it is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(held_mask, pressed_mask);
    end

    // Write one register; the enable drops at the following falling edge.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        board.write_reg(addr, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one frame item, opening a new burst after a random gap when the last one ran out.
    task automatic send_frame(input logic [MASK_W-1:0] mask);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
            burst_left = $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid   <= 1'b1;
        press_mask <= mask;
        do @(posedge clk); while (!in_ready);
        board.note_frame(mask);
    endtask

    // Stop offering and wait until every owed result has been taken.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (board.owed_masks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The receiver changes its pattern every stretch and honors a requested long hold-off.
    initial
    begin : result_sink
        int mode;
        int span;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            repeat (span)
            begin
                @(negedge clk);
                if (long_stall_req)
                begin
                    out_ready <= 1'b0;
                    repeat (LONG_STALL) @(negedge clk);
                    long_stall_req = 1'b0;
                end
                else
                begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= ($urandom_range(0, 1) == 0);
                        2:       out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    // End the run when nothing has been taken on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        logic [MASK_W-1:0]     plan_mask;
        logic [MASK_W-1:0]     keep_mask;
        logic [MASK_W-1:0]     mask;
        logic [CFG_DATA_W-1:0] delay;
        logic [CFG_DATA_W-1:0] rate;
        int                    toggle_div;
        int                    pick;

        board = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Writes past the register list must leave the defaults in force.
        write_reg(CFG_UNUSED_LO, 8'h01);
        write_reg(CFG_UNUSED_HI, 8'hFF);

        // Directed frames under the defaults: a long all-button hold reaches the repeat,
        // then release, alternating patterns and the buttons at both ends of the mask.
        send_frame('0);
        repeat (19) send_frame('1);
        send_frame('0);
        send_frame({(MASK_W/2){2'b01}});
        send_frame({(MASK_W/2){2'b10}});
        send_frame(LONG_HOLD);
        send_frame('0);
        drain_results();

        // Random phases: mostly held patterns that change slowly, some noise frames.
        plan_mask = '0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < PLANNED_PHASES)
            begin
                delay = PLAN_DELAY[ph];
                rate  = PLAN_RATE[ph];
            end
            else
            begin
                pick  = $urandom_range(0, 9);
                delay = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : (pick == 2) ? 8'd254 :
                        CFG_DATA_W'($urandom_range(1, 30));
                pick  = $urandom_range(0, 9);
                rate  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : (pick == 2) ? 8'd1 :
                        CFG_DATA_W'($urandom_range(1, 12));
            end
            write_reg(CFG_REPEAT_DELAY, delay);
            write_reg(CFG_REPEAT_RATE, rate);
            if (ph % 4 == 1)
                write_reg(CFG_UNUSED_HI, CFG_DATA_W'($urandom));
            if (ph == 2)
                long_stall_req = 1'b1;

            pick = $urandom_range(0, 2);
            toggle_div = (pick == 0) ? 4 : (pick == 1) ? 16 : 64;
            keep_mask = (ph == PHASES - 1) ? '0 : LONG_HOLD;

            for (int n = 0; n < FRAMES_PER_PHASE; n++)
            begin
                for (int b = 0; b < MASK_W; b++)
                begin
                    if ($urandom_range(0, toggle_div - 1) == 0)
                        plan_mask[b] = ~plan_mask[b];
                end
                if ($urandom_range(0, 9) == 0)
                    mask = {$urandom, $urandom};
                else
                    mask = plan_mask;
                send_frame(mask | keep_mask);
            end
            drain_results();
        end

        if (board.owed_masks.size() != 0)
        begin
            $error("%0d result items never arrived", board.owed_masks.size());
            board.failures++;
        end
        if (board.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bha_pkg.sv
rtl/core/bha_state_ram.sv
rtl/core/bha_update.sv
rtl/core/button_hold_autorepeat.sv
rtl/core/bha_checker.sv
dv/button_hold_autorepeat_tb.sv
